/* rtl/core/nne_pkg.sv */
// Shared types and constants for the NAND network evaluator.
// Holds the request and result payloads, operation and status codes, the controller
// state type and the command and status structs between controller and datapath.
package nne_pkg;

   localparam int OP_W       = 3;
   localparam int CSR_W      = 7;
   localparam int EXAMPLE_W  = 16;
   localparam int EXIDX_W    = 4;
   localparam int TARGET_W   = 64;
   localparam int MAX_OUTPUTS = 64;

   typedef enum logic [OP_W-1:0] {
      OP_MOVE       = 3'd0,
      OP_REVERT     = 3'd1,
      OP_REVERT_ALL = 3'd2,
      OP_CLEAR      = 3'd3,
      OP_EVAL       = 3'd4
   } nne_op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_REJECT = 2'd2
   } nne_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_MOVE_WR,
      S_REV_RD,
      S_REV_WR,
      S_EV_RUN,
      S_EV_FIN,
      S_EV_OUT
   } nne_state_type;

   typedef struct packed {
      logic [OP_W-1:0]      operation;
      logic [7:0]           gate_index;
      logic                 input_select;
      logic [8:0]           source_node;
      logic [EXAMPLE_W-1:0] example_inputs;
      logic [TARGET_W-1:0]  target_bits;
   } nne_req_type;

   typedef struct packed {
      logic [TARGET_W-1:0] output_bits;
      logic [TARGET_W-1:0] error_bits;
      logic                all_correct;
      logic [1:0]          status;
   } nne_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           load;
      logic           move_read;
      logic           move_write;
      logic           stack_read;
      logic           revert_write;
      logic           clear;
      logic           eval_start;
      logic           eval_finish;
      logic           respond;
      logic           rsp_eval;
      nne_status_type rsp_status;
   } nne_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            move_ok;
      logic            stack_empty;
      logic            last_entry;
      logic            eval_done;
   } nne_stat_type;

endpackage

/* rtl/core/nne_ctrl.sv */
// Controller state machine of the NAND network evaluator.
// Depends on nne_pkg; drives commands into nne_datapath and reads its status.
module nne_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  nne_pkg::nne_stat_type stat,
   output nne_pkg::nne_cmd_type  cmd
);
   import nne_pkg::*;

   nne_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.op)
               OP_MOVE:       state_in = stat.move_ok ? S_MOVE_WR : S_IDLE;
               OP_REVERT,
               OP_REVERT_ALL: state_in = stat.stack_empty ? S_IDLE : S_REV_RD;
               OP_EVAL:       state_in = S_EV_RUN;
               default:       state_in = S_IDLE;
            endcase
         end
         S_MOVE_WR: state_in = S_IDLE;
         S_REV_RD:  state_in = S_REV_WR;
         S_REV_WR: begin
            if (stat.op == OP_REVERT_ALL && !stat.last_entry) begin
               state_in = S_REV_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EV_RUN: begin
            if (stat.eval_done) begin
               state_in = S_EV_FIN;
            end
         end
         S_EV_FIN: state_in = S_EV_OUT;
         S_EV_OUT: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.rsp_status = ST_OK;
      busy           = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = start;
         end
         S_DISPATCH: begin
            unique case (stat.op)
               OP_MOVE: begin
                  if (stat.move_ok) begin
                     cmd.move_read = 1'b1;
                  end else begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_REJECT;
                  end
               end
               OP_REVERT: begin
                  if (stat.stack_empty) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                  end
               end
               OP_REVERT_ALL: begin
                  cmd.respond = stat.stack_empty;
               end
               OP_CLEAR: begin
                  cmd.clear   = 1'b1;
                  cmd.respond = 1'b1;
               end
               OP_EVAL: begin
                  cmd.eval_start = 1'b1;
               end
               default: begin
                  cmd.respond = 1'b1;
               end
            endcase
         end
         S_MOVE_WR: begin
            cmd.move_write = 1'b1;
            cmd.respond    = 1'b1;
         end
         S_REV_RD: begin
            cmd.stack_read = 1'b1;
         end
         S_REV_WR: begin
            cmd.revert_write = 1'b1;
            cmd.respond      = !(stat.op == OP_REVERT_ALL && !stat.last_entry);
         end
         S_EV_RUN: begin
         end
         S_EV_FIN: begin
            cmd.eval_finish = 1'b1;
         end
         S_EV_OUT: begin
            cmd.respond  = 1'b1;
            cmd.rsp_eval = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

/* rtl/core/nne_datapath.sv */
// Datapath of the NAND network evaluator: wiring memories, undo stack, gate value
// memory with its three-stage evaluation pipeline, and the result register.
// Depends on nne_pkg; commanded by nne_ctrl.
module nne_datapath #(
   parameter int INPUT_BITS = 16,
   parameter int GATE_COUNT = 256,
   parameter int UNDO_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  nne_pkg::nne_req_type           req_data,
   input  nne_pkg::nne_cmd_type           cmd,
   input  logic                           csr_we,
   input  logic [nne_pkg::CSR_W-1:0]      csr_wdata,
   output nne_pkg::nne_stat_type          stat,
   output logic                           rsp_strobe,
   output nne_pkg::nne_rsp_type           rsp_data
);
   import nne_pkg::*;

   localparam int NODE_COUNT = INPUT_BITS + GATE_COUNT;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int GATE_W     = $clog2(GATE_COUNT);
   localparam int UIDX_W     = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1;
   localparam int CNT_W      = $clog2(UNDO_DEPTH + 1);
   localparam int ENT_W      = GATE_W + 1 + NODE_W;
   localparam int MAX_OUT    = (GATE_COUNT < MAX_OUTPUTS) ? GATE_COUNT : MAX_OUTPUTS;

   localparam logic [GATE_W-1:0] LAST_GATE = GATE_W'(GATE_COUNT - 1);

   // Request and configuration registers.
   nne_req_type         req_ff;
   logic [CSR_W-1:0]    csr_ff;
   logic [CNT_W-1:0]    count_ff, count_in;

   // Memories and their registered read data.
   logic [NODE_W-1:0]   wire0_mem [GATE_COUNT];
   logic [NODE_W-1:0]   wire1_mem [GATE_COUNT];
   logic [ENT_W-1:0]    stack_mem [UNDO_DEPTH];
   logic                gate_mem  [GATE_COUNT];
   logic [NODE_W-1:0]   wire0_q_ff, wire1_q_ff;
   logic [ENT_W-1:0]    stack_q_ff;
   logic                gate_qa_ff, gate_qb_ff;

   // Evaluation pipeline.
   logic                issue_ff, issue_in;
   logic [GATE_W-1:0]   gcnt_ff, gcnt_in;
   logic                p1_vld_ff;
   logic [GATE_W-1:0]   p1_gate_ff;
   logic                p2_vld_ff;
   logic [GATE_W-1:0]   p2_gate_ff;
   logic                a_mem_ff, a_lit_ff, b_mem_ff, b_lit_ff;
   logic [GATE_W-1:0]   a_idx_ff, b_idx_ff;
   logic                fwd_vld_ff;
   logic [GATE_W-1:0]   fwd_idx_ff;
   logic                fwd_val_ff;
   logic [MAX_OUTPUTS-1:0] out_sr_ff;
   logic [MAX_OUTPUTS-1:0] obits_ff, mask_ff;

   // Result register.
   logic                rsp_strobe_ff;
   nne_rsp_type         rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic                wr_rd;
   logic [GATE_W-1:0]   wr_raddr;
   logic                w0_we, w1_we;
   logic [GATE_W-1:0]   w_waddr;
   logic [NODE_W-1:0]   w_wdata;
   logic [NODE_W-1:0]   old_src;
   logic [GATE_W-1:0]   ent_gate;
   logic                ent_sel;
   logic [NODE_W-1:0]   ent_src;
   logic [CNT_W-1:0]    count_m1;
   logic                a_mem, a_lit, b_mem, b_lit;
   logic [GATE_W-1:0]   a_idx, b_idx;
   logic                va, vb, nand_val;
   logic [6:0]          n_eff;
   logic [6:0]          shamt;
   logic [MAX_OUTPUTS-1:0] ebits;

   // A source below the primary input count reads the example bit; inputs past
   // the example width and sources past the last node read as zero.
   function automatic logic src_lit(input logic [NODE_W-1:0] s, input logic [EXAMPLE_W-1:0] ex);
      logic [31:0] s32;
      s32 = 32'(s);
      src_lit = (s32 < INPUT_BITS && s32 < EXAMPLE_W) ? ex[s32[EXIDX_W-1:0]] : 1'b0;
   endfunction

   function automatic logic src_mem(input logic [NODE_W-1:0] s);
      logic [31:0] s32;
      s32 = 32'(s);
      src_mem = (s32 >= INPUT_BITS) && (s32 < NODE_COUNT);
   endfunction

   function automatic logic [GATE_W-1:0] src_idx(input logic [NODE_W-1:0] s);
      logic [NODE_W-1:0] d;
      d = s - NODE_W'(INPUT_BITS);
      src_idx = d[GATE_W-1:0];
   endfunction

   assign count_m1 = count_ff - CNT_W'(1);
   assign ent_gate = stack_q_ff[ENT_W-1 -: GATE_W];
   assign ent_sel  = stack_q_ff[NODE_W];
   assign ent_src  = stack_q_ff[NODE_W-1:0];
   assign old_src  = req_ff.input_select ? wire1_q_ff : wire0_q_ff;

   // Status to the controller.
   always_comb begin
      stat.op          = req_ff.operation;
      stat.move_ok     = (32'(req_ff.gate_index) < GATE_COUNT) &&
                         (32'(req_ff.source_node) < INPUT_BITS + 32'(req_ff.gate_index)) &&
                         (32'(count_ff) < UNDO_DEPTH);
      stat.stack_empty = (count_ff == '0);
      stat.last_entry  = (count_ff == CNT_W'(1));
      stat.eval_done   = p2_vld_ff && (p2_gate_ff == LAST_GATE);
   end

   // Wiring memory ports.
   always_comb begin
      wr_rd    = cmd.move_read || issue_ff;
      wr_raddr = issue_ff ? gcnt_ff : GATE_W'(req_ff.gate_index);
      w0_we    = 1'b0;
      w1_we    = 1'b0;
      w_waddr  = GATE_W'(req_ff.gate_index);
      w_wdata  = NODE_W'(req_ff.source_node);
      if (cmd.move_write) begin
         w0_we = !req_ff.input_select;
         w1_we = req_ff.input_select;
      end else if (cmd.revert_write) begin
         w0_we   = !ent_sel;
         w1_we   = ent_sel;
         w_waddr = ent_gate;
         w_wdata = ent_src;
      end
   end

   always_ff @(posedge clock) begin
      if (w0_we) begin
         wire0_mem[w_waddr] <= w_wdata;
      end
      if (w1_we) begin
         wire1_mem[w_waddr] <= w_wdata;
      end
      if (wr_rd) begin
         wire0_q_ff <= wire0_mem[wr_raddr];
         wire1_q_ff <= wire1_mem[wr_raddr];
      end
   end

   // Undo stack.
   always_ff @(posedge clock) begin
      if (cmd.move_write) begin
         stack_mem[count_ff[UIDX_W-1:0]] <=
            {GATE_W'(req_ff.gate_index), req_ff.input_select, old_src};
      end
      if (cmd.stack_read) begin
         stack_q_ff <= stack_mem[count_m1[UIDX_W-1:0]];
      end
   end

   always_comb begin
      count_in = count_ff;
      priority if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.move_write) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.revert_write) begin
         count_in = count_m1;
      end
   end

   // Evaluation: issue reads the wiring, stage one decodes sources and reads gate
   // values, stage two forms the NAND and writes it back. Only the gate written on
   // the previous edge can be stale in the memory read, so one forward suffices.
   always_comb begin
      issue_in = issue_ff;
      gcnt_in  = gcnt_ff;
      if (cmd.eval_start) begin
         issue_in = 1'b1;
         gcnt_in  = '0;
      end else if (issue_ff) begin
         gcnt_in = gcnt_ff + GATE_W'(1);
         if (gcnt_ff == LAST_GATE) begin
            issue_in = 1'b0;
         end
      end
   end

   always_comb begin
      a_mem = src_mem(wire0_q_ff);
      a_lit = src_lit(wire0_q_ff, req_ff.example_inputs);
      a_idx = src_idx(wire0_q_ff);
      b_mem = src_mem(wire1_q_ff);
      b_lit = src_lit(wire1_q_ff, req_ff.example_inputs);
      b_idx = src_idx(wire1_q_ff);
   end

   always_ff @(posedge clock) begin
      if (p1_vld_ff) begin
         gate_qa_ff <= gate_mem[a_idx];
         gate_qb_ff <= gate_mem[b_idx];
      end
      if (p2_vld_ff) begin
         gate_mem[p2_gate_ff] <= nand_val;
      end
   end

   always_comb begin
      if (a_mem_ff) begin
         va = (fwd_vld_ff && fwd_idx_ff == a_idx_ff) ? fwd_val_ff : gate_qa_ff;
      end else begin
         va = a_lit_ff;
      end
      if (b_mem_ff) begin
         vb = (fwd_vld_ff && fwd_idx_ff == b_idx_ff) ? fwd_val_ff : gate_qb_ff;
      end else begin
         vb = b_lit_ff;
      end
      nand_val = !(va && vb);
   end

   // Output window: zero selects one output, larger counts saturate.
   always_comb begin
      n_eff = (csr_ff == '0) ? 7'd1 : csr_ff;
      if (32'(n_eff) > MAX_OUT) begin
         n_eff = 7'(MAX_OUT);
      end
      shamt = 7'(MAX_OUTPUTS) - n_eff;
      ebits = (obits_ff ^ req_ff.target_bits) & mask_ff;
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in.status = cmd.rsp_status;
      if (cmd.rsp_eval) begin
         rsp_data_in.output_bits = obits_ff;
         rsp_data_in.error_bits  = ebits;
         rsp_data_in.all_correct = (ebits == '0);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff        <= CSR_W'(1);
         count_ff      <= '0;
         issue_ff      <= 1'b0;
         p1_vld_ff     <= 1'b0;
         p2_vld_ff     <= 1'b0;
         fwd_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         p1_vld_ff     <= issue_ff;
         p2_vld_ff     <= p1_vld_ff;
         fwd_vld_ff    <= p2_vld_ff;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      gcnt_ff    <= gcnt_in;
      p1_gate_ff <= gcnt_ff;
      p2_gate_ff <= p1_gate_ff;
      a_mem_ff   <= a_mem;
      a_lit_ff   <= a_lit;
      a_idx_ff   <= a_idx;
      b_mem_ff   <= b_mem;
      b_lit_ff   <= b_lit;
      b_idx_ff   <= b_idx;
      fwd_idx_ff <= p2_gate_ff;
      fwd_val_ff <= nand_val;
      if (p2_vld_ff) begin
         out_sr_ff <= {nand_val, out_sr_ff[MAX_OUTPUTS-1:1]};
      end
      if (cmd.eval_finish) begin
         obits_ff <= out_sr_ff >> shamt;
         mask_ff  <= {MAX_OUTPUTS{1'b1}} >> shamt;
      end
      if (cmd.respond) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

/* rtl/core/nand_network_evaluator_core.sv */
// Top level of the NAND network evaluator core.
// Depends on nne_pkg and instantiates nne_ctrl and nne_datapath.
//
// The core holds a wiring table for a feedforward network of GATE_COUNT two-input
// NAND gates fed by INPUT_BITS primary inputs, and an undo stack of UNDO_DEPTH
// entries. A command is taken on a clock edge where start is high and busy is low;
// exactly one result follows on rsp_data, marked by rsp_strobe for a single cycle.
// The receiver cannot stall the result: it must capture the transfer in the cycle
// the strobe is high. Commands run one at a time. A clear, a revert on an empty
// stack, a rejected move or an unused code responds from dispatch; an accepted
// move then writes the wiring, a single revert reads its stack entry and then
// restores the wiring from it, a revert-all repeats that for each entry, and an
// evaluation runs the gates through the three-stage evaluation pipeline, one gate
// entering per cycle; the last gate must leave it before the output window is
// formed and the result is issued. A move is rejected with status 2 when the gate is
// beyond the network, the source is not an earlier node, or the undo stack is full.
// The output count register on csr_wdata may be written only while the core is idle;
// zero selects one output and large values saturate at 64 or GATE_COUNT. Wiring
// entries that no move ever wrote hold unknown sources until written.
module nand_network_evaluator_core #(
   parameter int INPUT_BITS = 16,
   parameter int GATE_COUNT = 256,
   parameter int UNDO_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  nne_pkg::nne_req_type      req_data,
   output logic                      rsp_strobe,
   output nne_pkg::nne_rsp_type      rsp_data,
   input  logic                      csr_we,
   input  logic [nne_pkg::CSR_W-1:0] csr_wdata
);
   import nne_pkg::*;

   // Commands and status between the state machine and the datapath.
   nne_cmd_type  cmd;
   nne_stat_type stat;

   // The controller sequences each command through dispatch, memory access and
   // the evaluation pipeline, and decides when the single result is issued.
   nne_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath owns every memory, the undo count, the output count register
   // and the result register that drives the result ports.
   nne_datapath #(
      .INPUT_BITS (INPUT_BITS),
      .GATE_COUNT (GATE_COUNT),
      .UNDO_DEPTH (UNDO_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
